[design/rcpdm_pkg.sv]
// ----------------------------------------------------------------------------
// rcpdm_pkg
// Types, constants and pulse decode helpers for the RC pulse drive mixer.
// ----------------------------------------------------------------------------
package rcpdm_pkg;

  // Pulse window and decode thresholds, in microseconds.
  localparam logic [15:0] PULSE_MIN  = 16'd800;
  localparam logic [15:0] PULSE_MAX  = 16'd2200;
  localparam logic [15:0] PULSE_MID  = 16'd1500;
  localparam logic [15:0] THR_FLOOR  = 16'd1000;
  localparam logic [15:0] THR_TOP    = 16'd2000;
  localparam logic [15:0] SW_LOW     = 16'd1300;
  localparam logic [15:0] SW_HIGH    = 16'd1700;

  // Stick clamp and full scale command.
  localparam logic [9:0]  HALF_SPAN  = 10'd500;
  localparam logic [9:0]  FULL_SCALE = 10'd1000;

  // Gripper servo pulse widths; all lie inside the 500 to 2500 servo range.
  localparam logic [11:0] SERVO_LOW  = 12'd1944;
  localparam logic [11:0] SERVO_MID  = 12'd1500;
  localparam logic [11:0] SERVO_HIGH = 12'd2278;

  // Lift speed indications.
  localparam logic signed [10:0] LIFT_SPEED_UP   = 11'sd1000;
  localparam logic signed [10:0] LIFT_SPEED_DOWN = -11'sd1000;
  localparam logic signed [1:0]  LIFT_MODE_UP    = 2'sd1;
  localparam logic signed [1:0]  LIFT_MODE_DOWN  = -2'sd1;

  // Shared multiplier. Division by 1000 is a multiply by ceil(2^35 / 1000)
  // and a shift by 35; it is exact for dividends below 2^35 / 632, and every
  // dividend here stays below 2^25.
  localparam int unsigned MulAW      = 25;
  localparam int unsigned MulBW      = 26;
  localparam int unsigned ProdW      = MulAW + MulBW;
  localparam int unsigned RecipShift = 35;
  localparam logic [MulBW-1:0] RECIP_1000 = 26'd34359739;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_DONE
  } state_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_DZ  = 3'd0,
    CFG_STOP_DZ    = 3'd1,
    CFG_RESTART_DZ = 3'd2,
    CFG_MAX_SPEED  = 3'd3,
    CFG_LIFT_STEPS = 3'd4
  } cfg_idx_e;

  // Three position switch decode.
  typedef enum logic [1:0] {
    POS_LOW  = 2'd0,
    POS_MID  = 2'd1,
    POS_HIGH = 2'd2
  } sw_pos_e;

  // Lift request codes.
  typedef enum logic [1:0] {
    LIFT_NONE = 2'd0,
    LIFT_UP   = 2'd1,
    LIFT_DOWN = 2'd2
  } lift_req_e;

  // A stick pulse split into validity, side of center and distance from it.
  typedef struct packed {
    logic       ok;
    logic       neg;
    logic [9:0] mag;
  } stick_t;

  function automatic logic pulse_ok(logic [15:0] p);
    return (p >= PULSE_MIN) && (p <= PULSE_MAX);
  endfunction

  function automatic stick_t stick_decode(logic [15:0] p);
    stick_t     s;
    logic [15:0] d;
    s.ok = pulse_ok(p);
    if (p >= PULSE_MID) begin
      s.neg = 1'b0;
      d     = p - PULSE_MID;
    end else begin
      s.neg = 1'b1;
      d     = PULSE_MID - p;
    end
    // A valid pulse is at most 700 away from center.
    s.mag = s.ok ? d[9:0] : 10'd0;
    return s;
  endfunction

  // An invalid stick counts as resting near center.
  function automatic logic stick_near(stick_t s, logic [8:0] band);
    return !s.ok || (s.mag <= {1'b0, band});
  endfunction

  // Magnitude of the command: zero inside the deadzone, else clamped and doubled.
  function automatic logic [9:0] cmd_mag(stick_t s, logic [8:0] dz);
    logic [9:0] c;
    if (!s.ok || (s.mag < {1'b0, dz})) begin
      c = 10'd0;
    end else if (s.mag > HALF_SPAN) begin
      c = HALF_SPAN;
    end else begin
      c = s.mag;
    end
    return {c[8:0], 1'b0};
  endfunction

  function automatic logic [9:0] throttle_scale(logic [15:0] p);
    logic [15:0] d;
    d = p - THR_FLOOR;
    if (!pulse_ok(p) || (p <= THR_FLOOR)) begin
      return 10'd0;
    end else if (p >= THR_TOP) begin
      return FULL_SCALE;
    end else begin
      return d[9:0];
    end
  endfunction

  function automatic sw_pos_e three_pos(logic [15:0] p);
    if (!pulse_ok(p)) begin
      return POS_MID;
    end else if (p <= SW_LOW) begin
      return POS_LOW;
    end else if (p >= SW_HIGH) begin
      return POS_HIGH;
    end else begin
      return POS_MID;
    end
  endfunction

endpackage

[design/rc_pulse_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// rc_pulse_drive_mixer_top
// Radio pulse mixer for a differential drive with gripper and lift outputs.
// ----------------------------------------------------------------------------
// One input beat carries a radio frame of pulse widths plus the line follow
// override; one output beat carries the wheel speeds, stick commands, throttle
// scale, gripper selection and lift request for that frame. Both channels use
// valid/ready. Configuration is a plain write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) that takes effect at once; write it only while idle.
// The sequencer steps through MUL1, DIV1, MUL2, DIV2 and DONE after the input
// beat is taken, and the result is registered on leaving DONE. A new frame is
// taken only in idle, once the single shared multiplier has been used four
// times: command times throttle, divide by 1000 as a reciprocal multiply,
// times max drive speed, and a second divide by 1000.
// The stop latch and lift edge state update when the input beat is taken.
// A new frame is taken while the previous result still waits in the output
// register; if the receiver stalls, the finished frame waits in the last
// sequencer state until the output register frees up.
// Reset sets the stop latch, clears lift history and loads the register
// defaults (center 40, stop 80, restart 120, max speed 20000).
module rc_pulse_drive_mixer_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           turn_pulse_i,
  input  logic [15:0]           move_pulse_i,
  input  logic [15:0]           throttle_pulse_i,
  input  logic [15:0]           gripper_switch_pulse_i,
  input  logic [15:0]           lift_switch_pulse_i,
  input  logic                  follow_active_i,
  input  logic signed [15:0]    follow_left_speed_i,
  input  logic signed [15:0]    follow_right_speed_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    left_drive_o,
  output logic signed [15:0]    right_drive_o,
  output logic signed [10:0]    move_command_o,
  output logic signed [10:0]    turn_command_o,
  output logic [9:0]            speed_scale_o,
  output logic [1:0]            gripper_position_o,
  output logic [11:0]           servo_pulse_o,
  output logic [1:0]            lift_request_o,
  output logic signed [1:0]     lift_mode_o,
  output logic signed [10:0]    lift_speed_o,
  output logic [31:0]           lift_trigger_total_o
);
  import rcpdm_pkg::*;

  // Configuration registers.
  logic [8:0]  cd_q, sd_q, rd_q;
  logic [14:0] mds_q;

  // Sequencer and frame state.
  state_e             state_q, state_d;
  logic               stop_q, stop_d;
  logic               lift_seen_q, lift_seen_d;
  sw_pos_e            lift_prev_q, lift_prev_d;
  logic signed [1:0]  lift_mode_q, lift_mode_d;
  logic signed [10:0] lift_speed_q, lift_speed_d;
  logic [31:0]        lift_count_q, lift_count_d;

  // Staged frame results, held while the multiplier works.
  logic signed [10:0] fwd_cmd_q, fwd_cmd_d;
  logic signed [10:0] yaw_cmd_q, yaw_cmd_d;
  logic [9:0]         scale_q, scale_d;
  sw_pos_e            grip_q, grip_d;
  logic [11:0]        servo_q, servo_d;
  lift_req_e          req_q, req_d;
  logic [9:0]         mix_mag_q, mix_mag_d;
  logic               mix_neg_q, mix_neg_d;
  logic               spin_q, spin_d;
  logic               follow_q;
  logic signed [15:0] fl_q, fr_q;

  // Shared multiplier.
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod_q;
  logic             prod_en;

  // Output register.
  logic               out_valid_q;
  logic               load_in, load_out;
  logic signed [15:0] tmag, tval, ldrive, rdrive;

  // Stick decode.
  stick_t     mv_s, tn_s;
  logic [9:0] mv_mag, tn_mag;
  logic       tn_neg;
  logic       both_near_stop, any_past_restart;
  sw_pos_e    lift_now;

  // Configuration writes; the lift step count affects no result and is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q  <= 9'd40;
      sd_q  <= 9'd80;
      rd_q  <= 9'd120;
      mds_q <= 15'd20000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_DZ:  cd_q  <= cfg_wdata_i[8:0];
        CFG_STOP_DZ:    sd_q  <= cfg_wdata_i[8:0];
        CFG_RESTART_DZ: rd_q  <= cfg_wdata_i[8:0];
        CFG_MAX_SPEED:  mds_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_d  = state_q;
    load_in  = 1'b0;
    load_out = 1'b0;
    prod_en  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_en = 1'b1;
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        prod_en = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_en = 1'b1;
        state_d = ST_DIV2;
      end
      ST_DIV2: begin
        prod_en = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Frame decode, stop latch and lift edge detection at the input beat.
  always_comb begin
    mv_s   = stick_decode(move_pulse_i);
    tn_s   = stick_decode(turn_pulse_i);
    mv_mag = cmd_mag(mv_s, cd_q);
    tn_mag = cmd_mag(tn_s, cd_q);
    // The turn command is the negated centered turn stick.
    tn_neg = !tn_s.neg;

    both_near_stop   = stick_near(mv_s, sd_q) && stick_near(tn_s, sd_q);
    any_past_restart = !stick_near(mv_s, rd_q) || !stick_near(tn_s, rd_q);

    priority if (both_near_stop) begin
      stop_d = 1'b1;
    end else if (stop_q && any_past_restart) begin
      stop_d = 1'b0;
    end else begin
      stop_d = stop_q;
    end

    // Commands read zero while the latch is set.
    if (stop_d) begin
      fwd_cmd_d = 11'sd0;
      yaw_cmd_d = 11'sd0;
    end else begin
      fwd_cmd_d = mv_s.neg ? -$signed({1'b0, mv_mag}) : $signed({1'b0, mv_mag});
      yaw_cmd_d = tn_neg ? -$signed({1'b0, tn_mag}) : $signed({1'b0, tn_mag});
    end

    // Pick the command that feeds the multiplier: spin wins over straight.
    priority if (stop_d) begin
      mix_mag_d = 10'd0;
      mix_neg_d = 1'b0;
      spin_d    = 1'b0;
    end else if (tn_mag != 10'd0) begin
      mix_mag_d = tn_mag;
      mix_neg_d = tn_neg;
      spin_d    = 1'b1;
    end else begin
      mix_mag_d = mv_mag;
      mix_neg_d = mv_s.neg;
      spin_d    = 1'b0;
    end

    scale_d = throttle_scale(throttle_pulse_i);
    grip_d  = three_pos(gripper_switch_pulse_i);
    unique case (grip_d)
      POS_HIGH: servo_d = SERVO_HIGH;
      POS_LOW:  servo_d = SERVO_LOW;
      default:  servo_d = SERVO_MID;
    endcase

    // Lift: the first frame only records the position; later a change to
    // high or low raises a request.
    lift_now     = three_pos(lift_switch_pulse_i);
    lift_seen_d  = 1'b1;
    lift_prev_d  = lift_now;
    lift_mode_d  = lift_mode_q;
    lift_speed_d = lift_speed_q;
    lift_count_d = lift_count_q;
    req_d        = LIFT_NONE;
    if (lift_seen_q && (lift_now != lift_prev_q)) begin
      if (lift_now == POS_HIGH) begin
        lift_mode_d  = LIFT_MODE_UP;
        lift_speed_d = LIFT_SPEED_UP;
        lift_count_d = lift_count_q + 32'd1;
        req_d        = LIFT_UP;
      end else if (lift_now == POS_LOW) begin
        lift_mode_d  = LIFT_MODE_DOWN;
        lift_speed_d = LIFT_SPEED_DOWN;
        lift_count_d = lift_count_q + 32'd1;
        req_d        = LIFT_DOWN;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stop_q       <= 1'b1;
      lift_seen_q  <= 1'b0;
      lift_prev_q  <= POS_MID;
      lift_mode_q  <= 2'sd0;
      lift_speed_q <= 11'sd0;
      lift_count_q <= 32'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_in) begin
        stop_q       <= stop_d;
        lift_seen_q  <= lift_seen_d;
        lift_prev_q  <= lift_prev_d;
        lift_mode_q  <= lift_mode_d;
        lift_speed_q <= lift_speed_d;
        lift_count_q <= lift_count_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Staged frame payload.
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      fwd_cmd_q  <= fwd_cmd_d;
      yaw_cmd_q  <= yaw_cmd_d;
      scale_q    <= scale_d;
      grip_q     <= grip_d;
      servo_q    <= servo_d;
      req_q      <= req_d;
      mix_mag_q  <= mix_mag_d;
      mix_neg_q  <= mix_neg_d;
      spin_q     <= spin_d;
      follow_q   <= follow_active_i;
      fl_q       <= follow_left_speed_i;
      fr_q       <= follow_right_speed_i;
    end
  end

  // Shared multiplier operands: magnitudes only, signs are applied at the end.
  always_comb begin
    unique case (state_q)
      ST_MUL1: begin
        mul_a = MulAW'(mix_mag_q);
        mul_b = MulBW'(scale_q);
      end
      ST_DIV1, ST_DIV2: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = RECIP_1000;
      end
      ST_MUL2: begin
        mul_a = MulAW'(prod_q[RecipShift +: 10]);
        mul_b = MulBW'(mds_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
  end

  // Wheel speeds: a spin drives both wheels to the same negated value.
  always_comb begin
    tmag = $signed({1'b0, prod_q[RecipShift +: 15]});
    tval = mix_neg_q ? -tmag : tmag;
    if (follow_q) begin
      ldrive = -fl_q;
      rdrive = fr_q;
    end else begin
      ldrive = -tval;
      rdrive = spin_q ? -tval : tval;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      left_drive_o         <= ldrive;
      right_drive_o        <= rdrive;
      move_command_o       <= fwd_cmd_q;
      turn_command_o       <= yaw_cmd_q;
      speed_scale_o        <= scale_q;
      gripper_position_o   <= grip_q;
      servo_pulse_o        <= servo_q;
      lift_request_o       <= req_q;
      lift_mode_o          <= lift_mode_q;
      lift_speed_o         <= lift_speed_q;
      lift_trigger_total_o <= lift_count_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[dv/rc_pulse_drive_mixer_top_tb.sv]
// ----------------------------------------------------------------------------
// rc_pulse_drive_mixer_top_tb
// Self-checking testbench for the RC pulse drive mixer.
// ----------------------------------------------------------------------------
// A short table of radio frames opens the run: pulse window edges, deadzone
// edges, stop latch hysteresis, line follow override and lift edges. Random
// frames follow over several register settings and idling phases. Every
// output beat is checked field by field against its typed row or a frame
// mixer model in this file, tracking stop latch, lift history and registers.
// ----------------------------------------------------------------------------
module rc_pulse_drive_mixer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpdm_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 138;

  // One radio frame as offered on the input channel.
  typedef struct {
    logic [15:0]        turn_p;
    logic [15:0]        move_p;
    logic [15:0]        thr_p;
    logic [15:0]        grip_p;
    logic [15:0]        lift_p;
    logic               follow;
    logic signed [15:0] left_cmd;
    logic signed [15:0] right_cmd;
  } frame_t;

  // One output beat.
  typedef struct {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic signed [10:0] fwd_cmd;
    logic signed [10:0] yaw_cmd;
    logic [9:0]         scale;
    sw_pos_e            grip_pos;
    logic [11:0]        servo;
    lift_req_e          lift_req;
    logic signed [1:0]  lift_mode;
    logic signed [10:0] lift_speed;
    logic [31:0]        lift_total;
  } mix_res_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    mix_res_t r;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [15:0]        turn_pulse_i;
  logic [15:0]        move_pulse_i;
  logic [15:0]        throttle_pulse_i;
  logic [15:0]        gripper_switch_pulse_i;
  logic [15:0]        lift_switch_pulse_i;
  logic               follow_active_i;
  logic signed [15:0] follow_left_speed_i;
  logic signed [15:0] follow_right_speed_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] left_drive_o;
  logic signed [15:0] right_drive_o;
  logic signed [10:0] move_command_o;
  logic signed [10:0] turn_command_o;
  logic [9:0]         speed_scale_o;
  logic [1:0]         gripper_position_o;
  logic [11:0]        servo_pulse_o;
  logic [1:0]         lift_request_o;
  logic signed [1:0]  lift_mode_o;
  logic signed [10:0] lift_speed_o;
  logic [31:0]        lift_trigger_total_o;

  rc_pulse_drive_mixer_top u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .turn_pulse_i           (turn_pulse_i),
    .move_pulse_i           (move_pulse_i),
    .throttle_pulse_i       (throttle_pulse_i),
    .gripper_switch_pulse_i (gripper_switch_pulse_i),
    .lift_switch_pulse_i    (lift_switch_pulse_i),
    .follow_active_i        (follow_active_i),
    .follow_left_speed_i    (follow_left_speed_i),
    .follow_right_speed_i   (follow_right_speed_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .left_drive_o           (left_drive_o),
    .right_drive_o          (right_drive_o),
    .move_command_o         (move_command_o),
    .turn_command_o         (turn_command_o),
    .speed_scale_o          (speed_scale_o),
    .gripper_position_o     (gripper_position_o),
    .servo_pulse_o          (servo_pulse_o),
    .lift_request_o         (lift_request_o),
    .lift_mode_o            (lift_mode_o),
    .lift_speed_o           (lift_speed_o),
    .lift_trigger_total_o   (lift_trigger_total_o)
  );

  // Register copies used by the mixer model.
  int cfg_center;
  int cfg_stop;
  int cfg_restart;
  int cfg_max_speed;
  int cfg_lift_steps;

  // Mixer model state.
  bit                 stop_q;
  bit                 lift_seen_q;
  sw_pos_e            lift_prev_q;
  logic signed [1:0]  lift_mode_q;
  logic signed [10:0] lift_speed_q;
  logic [31:0]        lift_total_q;

  mix_res_t pending_mix[$];
  dir_row_t dir_tab[$];
  int       err_cnt;
  int       tx_idle_pct;
  int       rx_stall_pct;
  int       rx_hold_reqs;
  int       quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Pulse window check shared by all channels.
  function automatic bit in_window(logic [15:0] p);
    return (p >= PULSE_MIN) && (p <= PULSE_MAX);
  endfunction

  // Centered stick command in -1000..1000, before the turn negation.
  function automatic int stick_cmd(logic [15:0] p);
    int v;
    if (!in_window(p)) return 0;
    v = int'(p) - int'(PULSE_MID);
    if (v > -cfg_center && v < cfg_center) return 0;
    if (v > 500) v = 500;
    else if (v < -500) v = -500;
    return (v * 1000) / 500;
  endfunction

  // An invalid stick counts as resting inside any band.
  function automatic bit stick_rest(logic [15:0] p, int band);
    int v;
    if (!in_window(p)) return 1'b1;
    v = int'(p) - int'(PULSE_MID);
    if (v < 0) v = -v;
    return v <= band;
  endfunction

  function automatic sw_pos_e switch_pos(logic [15:0] p);
    if (!in_window(p)) return POS_MID;
    if (p <= SW_LOW) return POS_LOW;
    if (p >= SW_HIGH) return POS_HIGH;
    return POS_MID;
  endfunction

  function automatic int clamp_full(int v);
    if (v > 1000) return 1000;
    if (v < -1000) return -1000;
    return v;
  endfunction

  // Mixer model: advances the latch and lift history by one frame.
  function automatic mix_res_t mix_frame(frame_t f);
    int       mv, tn, scale, s_move, s_turn, left, right, ldrive, rdrive;
    sw_pos_e  grip, lift;
    mix_res_t r;
    mv = stick_cmd(f.move_p);
    tn = -stick_cmd(f.turn_p);
    if (!in_window(f.thr_p) || f.thr_p <= THR_FLOOR) scale = 0;
    else if (f.thr_p >= THR_TOP) scale = 1000;
    else scale = int'(f.thr_p) - 1000;
    grip = switch_pos(f.grip_p);
    lift = switch_pos(f.lift_p);
    s_move = (mv * scale) / 1000;
    s_turn = (tn * scale) / 1000;

    // Stop latch with hysteresis between the two bands.
    if (stick_rest(f.move_p, cfg_stop) && stick_rest(f.turn_p, cfg_stop)) begin
      stop_q = 1'b1;
    end else if (stop_q && (!stick_rest(f.move_p, cfg_restart) ||
                            !stick_rest(f.turn_p, cfg_restart))) begin
      stop_q = 1'b0;
    end

    // Spin when turning, else drive straight.
    if (stop_q) begin
      mv = 0;
      tn = 0;
      left = 0;
      right = 0;
    end else if (tn != 0) begin
      left = s_turn;
      right = -s_turn;
    end else begin
      left = s_move;
      right = s_move;
    end
    left = clamp_full(left);
    right = clamp_full(right);

    if (f.follow) begin
      ldrive = -int'(f.left_cmd);
      rdrive = int'(f.right_cmd);
    end else begin
      ldrive = -((left * cfg_max_speed) / 1000);
      rdrive = (right * cfg_max_speed) / 1000;
    end

    case (grip)
      POS_HIGH: r.servo = SERVO_HIGH;
      POS_LOW:  r.servo = SERVO_LOW;
      default:  r.servo = SERVO_MID;
    endcase

    // Lift requests fire on a change of position only.
    r.lift_req = LIFT_NONE;
    if (!lift_seen_q) begin
      lift_prev_q = lift;
      lift_seen_q = 1'b1;
    end else if (lift != lift_prev_q) begin
      lift_prev_q = lift;
      if (lift == POS_HIGH) begin
        lift_mode_q = LIFT_MODE_UP;
        lift_speed_q = LIFT_SPEED_UP;
        lift_total_q = lift_total_q + 32'd1;
        r.lift_req = LIFT_UP;
      end else if (lift == POS_LOW) begin
        lift_mode_q = LIFT_MODE_DOWN;
        lift_speed_q = LIFT_SPEED_DOWN;
        lift_total_q = lift_total_q + 32'd1;
        r.lift_req = LIFT_DOWN;
      end
    end

    r.left_drive = ldrive[15:0];
    r.right_drive = rdrive[15:0];
    r.fwd_cmd = mv[10:0];
    r.yaw_cmd = tn[10:0];
    r.scale = scale[9:0];
    r.grip_pos = grip;
    r.lift_mode = lift_mode_q;
    r.lift_speed = lift_speed_q;
    r.lift_total = lift_total_q;
    return r;
  endfunction

  function automatic frame_t mk_frame(int turn_p, int move_p, int thr_p, int grip_p,
                                      int lift_p, bit follow, int fl, int fr);
    frame_t f;
    f.turn_p = turn_p[15:0];
    f.move_p = move_p[15:0];
    f.thr_p = thr_p[15:0];
    f.grip_p = grip_p[15:0];
    f.lift_p = lift_p[15:0];
    f.follow = follow;
    f.left_cmd = fl[15:0];
    f.right_cmd = fr[15:0];
    return f;
  endfunction

  function automatic mix_res_t mk_res(int ld, int rd, int mv, int tn, int sc, sw_pos_e gp,
                                      int sv, lift_req_e rq, int md, int spd, int tot);
    mix_res_t r;
    r.left_drive = ld[15:0];
    r.right_drive = rd[15:0];
    r.fwd_cmd = mv[10:0];
    r.yaw_cmd = tn[10:0];
    r.scale = sc[9:0];
    r.grip_pos = gp;
    r.servo = sv[11:0];
    r.lift_req = rq;
    r.lift_mode = md[1:0];
    r.lift_speed = spd[10:0];
    r.lift_total = tot;
    return r;
  endfunction

  task automatic add_plain(frame_t f);
    dir_row_t row;
    row.f = f;
    row.typed = 1'b0;
    dir_tab.push_back(row);
  endtask

  task automatic add_typed(frame_t f, mix_res_t r);
    dir_row_t row;
    row.f = f;
    row.typed = 1'b1;
    row.r = r;
    dir_tab.push_back(row);
  endtask

  // Stick pulses: mostly valid, clustered near center and the band edges.
  function automatic logic [15:0] rand_stick();
    logic [15:0] edges [6];
    int          off;
    edges = '{16'd0, 16'd799, 16'd800, 16'd2200, 16'd2201, 16'hFFFF};
    off = 0;
    case ($urandom_range(11))
      0: return 16'($urandom);
      1: return edges[$urandom_range(5)];
      2, 3: return 16'($urandom_range(2200, 800));
      4, 5, 6: off = int'($urandom_range(120)) - 60;
      7, 8: begin
        case ($urandom_range(2))
          0: off = cfg_center;
          1: off = cfg_stop;
          default: off = cfg_restart;
        endcase
        off = off + int'($urandom_range(2)) - 1;
        if ($urandom_range(1) == 1) off = -off;
      end
      default: off = int'($urandom_range(600)) - 300;
    endcase
    return 16'(1500 + off);
  endfunction

  // Three position switch pulses: the three zones, their edges and noise.
  function automatic logic [15:0] rand_switch();
    logic [15:0] edges [8];
    edges = '{16'd799, 16'd800, 16'd1300, 16'd1301, 16'd1699, 16'd1700, 16'd2200, 16'd2201};
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: return edges[$urandom_range(7)];
      2, 3: return 16'($urandom_range(1300, 800));
      4, 5: return 16'($urandom_range(1699, 1301));
      default: return 16'($urandom_range(2200, 1700));
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t      f;
    logic [15:0] thr_edges [8];
    thr_edges = '{16'd800, 16'd999, 16'd1000, 16'd1001, 16'd1999, 16'd2000, 16'd2001,
                  16'd2200};
    f.turn_p = rand_stick();
    f.move_p = rand_stick();
    // Both sticks at rest now and then, so the stop latch gets set often.
    if ($urandom_range(7) == 0) begin
      f.turn_p = 16'(1480 + $urandom_range(40));
      f.move_p = 16'(1480 + $urandom_range(40));
    end
    case ($urandom_range(7))
      0: f.thr_p = 16'($urandom);
      1: f.thr_p = thr_edges[$urandom_range(7)];
      default: f.thr_p = 16'($urandom_range(2200, 800));
    endcase
    f.grip_p = rand_switch();
    f.lift_p = rand_switch();
    f.follow = ($urandom_range(3) == 0);
    f.left_cmd = 16'($urandom);
    f.right_cmd = 16'($urandom);
    return f;
  endfunction

  // Offer one frame and hold it until the beat is taken.
  task automatic send_frame(frame_t f, bit typed, mix_res_t typed_res);
    mix_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    turn_pulse_i <= f.turn_p;
    move_pulse_i <= f.move_p;
    throttle_pulse_i <= f.thr_p;
    gripper_switch_pulse_i <= f.grip_p;
    lift_switch_pulse_i <= f.lift_p;
    follow_active_i <= f.follow;
    follow_left_speed_i <= f.left_cmd;
    follow_right_speed_i <= f.right_cmd;
    do @(posedge clk_i); while (!in_ready_o);
    r = mix_frame(f);
    pending_mix.push_back(typed ? typed_res : r);
  endtask

  // Stop offering and wait for every pending beat, then let the pipe empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all five registers one after another while the block is idle.
  task automatic load_regs(int cd, int sd, int rd, int spd, int steps);
    logic [15:0] vals [5];
    cfg_idx_e    idx;
    vals = '{cd[15:0], sd[15:0], rd[15:0], spd[15:0], steps[15:0]};
    idx = idx.first();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      case (idx)
        CFG_CENTER_DZ:  cfg_center = int'(vals[i][8:0]);
        CFG_STOP_DZ:    cfg_stop = int'(vals[i][8:0]);
        CFG_RESTART_DZ: cfg_restart = int'(vals[i][8:0]);
        CFG_MAX_SPEED:  cfg_max_speed = int'(vals[i][14:0]);
        default:        cfg_lift_steps = int'(vals[i]);
      endcase
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(string nm, logic signed [32:0] exp_v, logic signed [32:0] act_v);
    if (act_v !== exp_v) begin
      $display("[%0t ns] %s mismatch: expected %0d, actual %0d", $time, nm, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Output checker: each beat against the oldest pending expectation.
  always @(posedge clk_i) begin : out_check
    mix_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mix.size() == 0) begin
        $display("[%0t ns] output beat with nothing pending", $time);
        err_cnt++;
      end else begin
        e = pending_mix.pop_front();
        check_field("left_drive", e.left_drive, left_drive_o);
        check_field("right_drive", e.right_drive, right_drive_o);
        check_field("move_command", e.fwd_cmd, move_command_o);
        check_field("turn_command", e.yaw_cmd, turn_command_o);
        check_field("throttle scale", e.scale, speed_scale_o);
        check_field("gripper_position", e.grip_pos, gripper_position_o);
        check_field("servo_pulse", e.servo, servo_pulse_o);
        check_field("lift_request", e.lift_req, lift_request_o);
        check_field("lift_mode", e.lift_mode, lift_mode_o);
        check_field("lift_speed", e.lift_speed, lift_speed_o);
        check_field("lift_trigger_total", e.lift_total, lift_trigger_total_o);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : rx_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != rx_hold_reqs) begin
        hold_seen = rx_hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[%0t ns] no beat for %0d cycles", $time, QuietLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed table, then random frames over several phases.
  initial begin : stim
    int       ph_tx [6];
    int       ph_rx [6];
    mix_res_t unused_res;
    ph_tx = '{0, 54, 0, 19, 0, 19};
    ph_rx = '{0, 0, 54, 19, 0, 19};
    err_cnt = 0;
    rx_hold_reqs = 0;
    quiet_cycles = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;

    // Register defaults and model state after reset.
    cfg_center = 40;
    cfg_stop = 80;
    cfg_restart = 120;
    cfg_max_speed = 20000;
    cfg_lift_steps = 5000;
    stop_q = 1'b1;
    lift_seen_q = 1'b0;
    lift_prev_q = POS_MID;
    lift_mode_q = '0;
    lift_speed_q = '0;
    lift_total_q = '0;
    unused_res = mk_res(0, 0, 0, 0, 0, POS_MID, 0, LIFT_NONE, 0, 0, 0);

    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_CENTER_DZ;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    turn_pulse_i <= '0;
    move_pulse_i <= '0;
    throttle_pulse_i <= '0;
    gripper_switch_pulse_i <= '0;
    lift_switch_pulse_i <= '0;
    follow_active_i <= 1'b0;
    follow_left_speed_i <= '0;
    follow_right_speed_i <= '0;

    // Directed frames; typed rows hold results read straight off the spec.
    // First frame: sticks centered, latch set, lift position only recorded.
    add_typed(mk_frame(1500, 1500, 1500, 1500, 1500, 0, 0, 0),
              mk_res(0, 0, 0, 0, 500, POS_MID, 1500, LIFT_NONE, 0, 0, 0));
    // All pulses out of window; line follow speeds at the extremes wrap.
    add_typed(mk_frame(0, 0, 0, 0, 0, 1, -32768, 32767),
              mk_res(-32768, 32767, 0, 0, 0, POS_MID, 1500, LIFT_NONE, 0, 0, 0));
    // Full forward at full throttle, gripper and lift high.
    add_typed(mk_frame(1500, 2200, 2200, 2200, 2200, 0, 0, 0),
              mk_res(-20000, 20000, 1000, 0, 1000, POS_HIGH, 2278, LIFT_UP, 1, 1000, 1));
    // Full reverse at zero throttle, gripper and lift low.
    add_typed(mk_frame(1500, 800, 1000, 800, 800, 0, 0, 0),
              mk_res(0, 0, -1000, 0, 0, POS_LOW, 1944, LIFT_DOWN, -1, -1000, 2));
    // Full turn spins the wheels; lift stays low so no new request.
    add_typed(mk_frame(2200, 1500, 2000, 1300, 1300, 0, 0, 0),
              mk_res(20000, 20000, 0, -1000, 1000, POS_LOW, 1944, LIFT_NONE, -1, -1000, 2));
    // Inside the center deadzone, both at rest: latch set; lift back to middle.
    add_plain(mk_frame(1500, 1539, 1500, 1301, 1500, 0, 0, 0));
    // On the restart edge the latch holds, one past it the latch clears.
    add_plain(mk_frame(1500, 1620, 1500, 1500, 1500, 0, 0, 0));
    add_plain(mk_frame(1500, 1621, 1500, 1500, 1500, 0, 0, 0));
    add_plain(mk_frame(1460, 1700, 1999, 1500, 1500, 0, 0, 0));
    // Invalid sticks count as at rest.
    add_plain(mk_frame(2201, 799, 999, 1500, 1500, 0, 0, 0));
    add_plain(mk_frame(1500, 801, 2001, 1699, 1700, 0, 0, 0));
    add_plain(mk_frame(1501, 1499, 1200, 1700, 1699, 1, 12345, -4321));
    add_plain(mk_frame(801, 2199, 1750, 799, 799, 0, 0, 0));
    add_plain(mk_frame(1620, 1380, 1001, 1500, 1500, 0, 0, 0));
    add_plain(mk_frame(65535, 65535, 65535, 65535, 65535, 1, 32767, -32768));
    add_plain(mk_frame(2000, 1000, 1600, 2000, 1000, 0, 0, 0));
    add_plain(mk_frame(1050, 1950, 2100, 1500, 1300, 0, 0, 0));
    add_plain(mk_frame(1500, 1800, 1100, 1500, 2200, 1, -1, 1));
    add_plain(mk_frame(1200, 1500, 1900, 1500, 2200, 0, 0, 0));
    add_plain(mk_frame(1500, 1500, 1500, 1500, 1500, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_frame(dir_tab[i].f, dir_tab[i].typed, dir_tab[i].r);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_regs(0, 0, 0, 0, 0);
        1: load_regs(500, 500, 500, 32767, 65535);
        3: load_regs(40, 80, 120, 20000, 5000);
        default: load_regs($urandom_range(500), $urandom_range(500), $urandom_range(500),
                           $urandom_range(32767), $urandom_range(65535));
      endcase
      tx_idle_pct = ph_tx[ph];
      rx_stall_pct = ph_rx[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        // Long receiver hold-off while frames keep coming.
        if (ph == 2 && n == 30) rx_hold_reqs++;
        // Sender pause until the block has drained.
        if (ph == 3 && n == 70) settle();
        send_frame(rand_frame(), 1'b0, unused_res);
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
